>>> design/jlf_pkg.sv
// jlf_pkg: shared constants, codes and types of the json lines framer
// used by jlf_step, jlf_fifo and json_lines_framer; depends on nothing
`default_nettype none

package jlf_pkg;

  // widths of the line byte counter and of the limit register
  localparam int COUNT_WIDTH = 21;
  localparam int LIMIT_WIDTH = 21;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(1024 * 1024);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};

  // request commands
  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  // special bytes
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_WIDTH  = $clog2(FIFO_DEPTH);
  localparam int FCNT_WIDTH = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
  } result_t;

  // up to two results from one request, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

>>> design/jlf_fifo.sv
// jlf_fifo: small result queue that takes up to two results a cycle and
// gives one while out_ready is high; depends on jlf_pkg
`default_nettype none

module jlf_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire jlf_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          kind,
  output logic [7:0]          out_byte
);
  import jlf_pkg::*;

  result_t                mem [FIFO_DEPTH];
  logic [PTR_WIDTH-1:0]   wr_ptr;
  logic [PTR_WIDTH-1:0]   rd_ptr;
  logic [FCNT_WIDTH-1:0]  count;
  logic                   pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign room      = (count <= FCNT_WIDTH'(FIFO_DEPTH - 2));
  assign kind      = mem[rd_ptr].kind;
  assign out_byte  = mem[rd_ptr].out_byte;

  // storage writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + PTR_WIDTH'(1)] <= push.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_WIDTH'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_WIDTH'(1);
      end
      count <= count + FCNT_WIDTH'(push.n) - FCNT_WIDTH'(pop);
    end
  end

endmodule

`default_nettype wire

>>> design/jlf_step.sv
// jlf_step: input register and line state; works one request a cycle into
// up to two results for the queue while the queue has room; depends on jlf_pkg
`default_nettype none

module jlf_step (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       command,
  input  wire logic [7:0]                       data_byte,
  input  wire logic [jlf_pkg::LIMIT_WIDTH-1:0]  max_line_bytes,
  input  wire logic                             room,
  output jlf_pkg::push_t                        push
);
  import jlf_pkg::*;

  logic                   stage_valid;
  logic [1:0]             stage_cmd;
  logic [7:0]             stage_byte;
  logic                   fire;

  logic [COUNT_WIDTH-1:0] line_count;
  logic [COUNT_WIDTH-1:0] line_count_next;
  logic                   cr_pending;
  logic                   cr_pending_next;
  logic                   frame_started;
  logic                   frame_started_next;
  logic                   over_limit;
  push_t                  res;

  assign fire     = stage_valid && room;
  assign in_ready = !stage_valid || fire;
  assign push     = fire ? res : '0;

  assign over_limit = (max_line_bytes != '0) &&
                      (CMP_WIDTH'(line_count) >= CMP_WIDTH'(max_line_bytes));

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_cmd  <= command;
      stage_byte <= data_byte;
    end
  end

  // per request line logic
  always_comb begin
    line_count_next    = line_count;
    cr_pending_next    = cr_pending;
    frame_started_next = frame_started;
    res                = '0;
    unique case (stage_cmd)
      CMD_DATA: begin
        priority if (stage_byte == CH_LF) begin
          if (frame_started) begin
            res.n       = 2'd1;
            res.r0.kind = KIND_END;
          end
          line_count_next    = '0;
          cr_pending_next    = 1'b0;
          frame_started_next = 1'b0;
        end else if (over_limit) begin
          if (frame_started) begin
            res.n       = 2'd1;
            res.r0.kind = KIND_ABORT;
          end
          line_count_next    = '0;
          cr_pending_next    = 1'b0;
          frame_started_next = 1'b0;
        end else begin
          if (line_count != COUNT_MAX) begin
            line_count_next = line_count + COUNT_WIDTH'(1);
          end
          // held cr leaves first, then the new byte unless it is a cr
          res.r0.kind     = KIND_DATA;
          res.r0.out_byte = cr_pending ? CH_CR : stage_byte;
          res.r1.kind     = KIND_DATA;
          res.r1.out_byte = stage_byte;
          res.n = 2'(cr_pending) + 2'(stage_byte != CH_CR);
          cr_pending_next = (stage_byte == CH_CR);
          if (cr_pending || stage_byte != CH_CR) begin
            frame_started_next = 1'b1;
          end
        end
      end
      CMD_FLUSH: begin
        if (frame_started) begin
          res.n       = 2'd1;
          res.r0.kind = KIND_END;
        end
        line_count_next    = '0;
        cr_pending_next    = 1'b0;
        frame_started_next = 1'b0;
      end
      CMD_RESET: begin
        if (frame_started) begin
          res.n       = 2'd1;
          res.r0.kind = KIND_ABORT;
        end
        line_count_next    = '0;
        cr_pending_next    = 1'b0;
        frame_started_next = 1'b0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= '0;
      cr_pending    <= 1'b0;
      frame_started <= 1'b0;
    end else if (fire) begin
      line_count    <= line_count_next;
      cr_pending    <= cr_pending_next;
      frame_started <= frame_started_next;
    end
  end

endmodule

`default_nettype wire

>>> design/json_lines_framer.sv
// json_lines_framer: top level of the ndjson line framer with its limit register
// depends on jlf_pkg, jlf_step and jlf_fifo
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    command, data_byte
//   out      output     out_valid/out_ready  kind, out_byte
//   cfg      input      cfg_write            cfg_data (max_line_bytes)
//
// one request a cycle; each request passes the input register, and its results
// are written into a four entry result queue as it leaves that register. the
// queue drains one result a cycle; any request is held in the input register
// while the queue has fewer than two free entries. reset clears the queue, the
// line state and sets the limit to 1048576. an output stall backs up into
// in_ready.
`default_nettype none

module json_lines_framer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       command,
  input  wire logic [7:0]                       data_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            kind,
  output logic [7:0]                            out_byte,
  input  wire logic                             cfg_write,
  input  wire logic [jlf_pkg::LIMIT_WIDTH-1:0]  cfg_data
);
  import jlf_pkg::*;

  logic [LIMIT_WIDTH-1:0] max_line_bytes;
  logic                   room;
  push_t                  push;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_bytes <= LIMIT_RESET;
    end else if (cfg_write) begin
      max_line_bytes <= cfg_data;
    end
  end

  // line state and request decode
  jlf_step u_step (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .data_byte      (data_byte),
    .max_line_bytes (max_line_bytes),
    .room           (room),
    .push           (push)
  );

  // result queue
  jlf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte)
  );

endmodule

`default_nettype wire

>>> sim/json_lines_framer_tb.sv
// json_lines_framer_tb: self-checking bench for the ndjson line framer, directed table then
// random line traffic over several limit settings; depends on jlf_pkg and json_lines_framer
module json_lines_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jlf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 285;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = {LIMIT_WIDTH{1'b1}};
  localparam result_t NO_RESULT = '{KIND_DATA, 8'h00};

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_in;
    logic       typed;
    push_t      want;
  } dir_row_t;

  // directed rows, run with a line limit of two; rows not typed use the predictor
  localparam dir_row_t DIRECTED [25] = '{
    '{CMD_DATA,   8'h00, 1'b1, '{2'd1, '{KIND_DATA, 8'h00}, NO_RESULT}},
    '{CMD_DATA,   8'hFF, 1'b1, '{2'd1, '{KIND_DATA, 8'hFF}, NO_RESULT}},
    '{CMD_DATA,   8'h41, 1'b1, '{2'd1, '{KIND_ABORT, 8'h00}, NO_RESULT}},
    '{CMD_DATA,   CH_LF, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_DATA,   CH_CR, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_DATA,   CH_LF, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_DATA,   CH_CR, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_DATA,   8'h42, 1'b1, '{2'd2, '{KIND_DATA, CH_CR}, '{KIND_DATA, 8'h42}}},
    '{CMD_DATA,   CH_LF, 1'b1, '{2'd1, '{KIND_END, 8'h00}, NO_RESULT}},
    '{CMD_DATA,   CH_CR, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_DATA,   CH_CR, 1'b0, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_DATA,   8'h43, 1'b1, '{2'd1, '{KIND_ABORT, 8'h00}, NO_RESULT}},
    '{CMD_DATA,   CH_CR, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_FLUSH,  8'hFF, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_DATA,   8'h55, 1'b1, '{2'd1, '{KIND_DATA, 8'h55}, NO_RESULT}},
    '{CMD_DATA,   8'h7E, 1'b1, '{2'd1, '{KIND_DATA, 8'h7E}, NO_RESULT}},
    '{CMD_DATA,   CH_LF, 1'b1, '{2'd1, '{KIND_END, 8'h00}, NO_RESULT}},
    '{CMD_DATA,   8'hAA, 1'b1, '{2'd1, '{KIND_DATA, 8'hAA}, NO_RESULT}},
    '{CMD_FLUSH,  8'h00, 1'b1, '{2'd1, '{KIND_END, 8'h00}, NO_RESULT}},
    '{CMD_DATA,   8'h01, 1'b0, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_RESET,  8'h80, 1'b1, '{2'd1, '{KIND_ABORT, 8'h00}, NO_RESULT}},
    '{CMD_UNUSED, 8'h5A, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_DATA,   CH_CR, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_UNUSED, 8'hFF, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}},
    '{CMD_FLUSH,  8'h00, 1'b1, '{2'd0, NO_RESULT, NO_RESULT}}
  };

  // limits of the random phases; the last one is drawn at run time
  localparam logic [LIMIT_WIDTH-1:0] PHASE_LIMITS [RANDOM_PHASES] = '{
    LIMIT_RESET, 21'd0, 21'd1, 21'd5, LIMIT_MAX, 21'd12, 21'd0
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             command = CMD_DATA;
  logic [7:0]             data_byte = 8'h00;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             kind;
  logic [7:0]             out_byte;
  logic                   cfg_write = 1'b0;
  logic [LIMIT_WIDTH-1:0] cfg_data = '0;

  // framer state as the bench sees it
  logic [COUNT_WIDTH-1:0] line_len = '0;
  logic                   cr_held = 1'b0;
  logic                   frame_open = 1'b0;
  logic [LIMIT_WIDTH-1:0] line_limit = LIMIT_RESET;

  result_t due_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int in_calm = 0;
  int out_calm = 0;

  json_lines_framer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void append_result(inout push_t p, input logic [1:0] k,
                                        input logic [7:0] b);
    if (p.n == 2'd0) p.r0 = '{kind: k, out_byte: b};
    else p.r1 = '{kind: k, out_byte: b};
    p.n = p.n + 2'd1;
  endfunction

  function automatic void clear_line_state();
    line_len = '0;
    cr_held = 1'b0;
    frame_open = 1'b0;
  endfunction

  // results of one request, and the line state it leaves behind
  function automatic push_t frame_request(input logic [1:0] cmd, input logic [7:0] b);
    push_t p;
    p = '0;
    case (cmd)
      CMD_DATA: begin
        if (b == CH_LF) begin
          // a held cr is dropped, lf closes a started frame
          if (frame_open) append_result(p, KIND_END, 8'h00);
          clear_line_state();
        end else if (line_limit != '0 && line_len >= line_limit) begin
          // line too long: drop everything, abort what already left
          if (frame_open) append_result(p, KIND_ABORT, 8'h00);
          clear_line_state();
        end else begin
          if (line_len != COUNT_MAX) line_len = line_len + COUNT_WIDTH'(1);
          if (cr_held) begin
            append_result(p, KIND_DATA, CH_CR);
            frame_open = 1'b1;
            cr_held = 1'b0;
          end
          if (b == CH_CR) begin
            cr_held = 1'b1;
          end else begin
            append_result(p, KIND_DATA, b);
            frame_open = 1'b1;
          end
        end
      end
      CMD_FLUSH: begin
        if (frame_open) append_result(p, KIND_END, 8'h00);
        clear_line_state();
      end
      CMD_RESET: begin
        if (frame_open) append_result(p, KIND_ABORT, 8'h00);
        clear_line_state();
      end
      default: ;
    endcase
    return p;
  endfunction

  // idle length: mostly none or short, a few long, now and then a calm stretch
  function automatic int pick_pause(inout int calm);
    int r;
    if (calm != 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(50, 250);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] b,
                              input logic typed, input push_t typed_res);
    int pause;
    push_t predicted;
    pause = pick_pause(in_calm);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    predicted = frame_request(cmd, b);
    if (typed) predicted = typed_res;
    if (predicted.n != 2'd0) due_results.push_back(predicted.r0);
    if (predicted.n == 2'd2) due_results.push_back(predicted.r1);
  endtask

  // limit write once the block has gone quiet
  task automatic set_limit(input logic [LIMIT_WIDTH-1:0] value);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    line_limit = value;
  endtask

  // output side stalls
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_pause(out_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // compare each result with the oldest one due
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, kind %0d byte %02h", $time, kind, out_byte);
      end else begin
        want = due_results.pop_front();
        if (kind !== want.kind) begin
          mismatches++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
        end
        if (out_byte !== want.out_byte) begin
          mismatches++;
          $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte,
                   out_byte);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL json_lines_framer");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int r;
    logic [LIMIT_WIDTH-1:0] lim;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    set_limit(21'd2);
    foreach (DIRECTED[i])
      send_request(DIRECTED[i].cmd, DIRECTED[i].byte_in, DIRECTED[i].typed,
                   DIRECTED[i].want);

    // random lines, mostly well formed, with flushes, resets and stray commands
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      lim = (ph == RANDOM_PHASES - 1) ? LIMIT_WIDTH'($urandom_range(0, 64))
                                      : PHASE_LIMITS[ph];
      set_limit(lim);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_request(CMD_FLUSH, 8'($urandom), 1'b0, '0);
          sent++;
        end else if (r < 5) begin
          send_request(CMD_RESET, 8'($urandom), 1'b0, '0);
          sent++;
        end else if (r < 6) begin
          send_request(CMD_UNUSED, 8'($urandom), 1'b0, '0);
        end else if (r < 18) begin
          // line end, half of them as cr lf
          if ($urandom_range(0, 1) == 1) begin
            send_request(CMD_DATA, CH_CR, 1'b0, '0);
            sent++;
          end
          send_request(CMD_DATA, CH_LF, 1'b0, '0);
          sent++;
        end else if (r < 26) begin
          send_request(CMD_DATA, CH_CR, 1'b0, '0);
          sent++;
        end else begin
          send_request(CMD_DATA, 8'($urandom), 1'b0, '0);
          sent++;
        end
      end
    end

    // drain and report
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS json_lines_framer");
    else $display("FAIL json_lines_framer");
    $finish;
  end

endmodule

>>> sim.f
design/jlf_pkg.sv
design/jlf_fifo.sv
design/jlf_step.sv
design/json_lines_framer.sv
sim/json_lines_framer_tb.sv
